// File: design/sidec_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package sidec_pkg;

    // Field widths and defaults
    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_DIGITS_DEF = 10;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 8;
    localparam int POS_W          = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Converter sequencer
    typedef enum logic [1:0] {
        C_IDLE,
        C_SHIFT,
        C_DONE
    } conv_state_t;

    // Character emitter sequencer
    typedef enum logic [1:0] {
        E_IDLE,
        E_STRIP,
        E_SIGN,
        E_DIGITS
    } emit_state_t;

    // Converter to emitter handoff
    typedef struct packed {
        logic valid;
        logic neg;
    } conv_ctl_t;

endpackage

// File: design/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter.
// Converts one two's-complement integer into its decimal text, one ASCII character per
// output item, most significant digit first, with a leading '-' for negative values and
// no leading zeros; char_position counts from 1 and is_last marks the final character.
// Each integer is accepted, run through the bit-serial shift-and-add-3 converter over its
// DATA_WIDTH magnitude bits, and its digits are handed to the emitter, which drops the
// leading zeros one per cycle (up to NUM_DIGITS-1) and then sends one character per
// cycle (up to 11 at the default width) while the result side keeps m_ready high.
// The converter holds one integer at a time; the next is taken once its digits have been
// handed to the emitter, while the emitter may still be sending the previous text. With
// m_ready held high, the converter sets the rate at which new integers are taken.
module signed_int_to_decimal_ascii_top #(
    parameter int DATA_WIDTH = sidec_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [DATA_WIDTH-1:0]         s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sidec_pkg::CHAR_W-1:0]  m_ascii_char,
    output logic [sidec_pkg::POS_W-1:0]   m_char_position,
    output logic                          m_is_last
);
    import sidec_pkg::*;

    // enough decimal digits for 2**DATA_WIDTH
    localparam int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;

    conv_ctl_t                      conv_ctl;
    logic [NUM_DIGITS*DIGIT_W-1:0]  conv_bcd;
    logic                           emit_ready;

    // Binary to BCD
    sidec_dabble #(
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .ctl_o   (conv_ctl),
        .bcd_o   (conv_bcd),
        .take_i  (emit_ready)
    );

    // BCD to characters
    sidec_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl_i           (conv_ctl),
        .bcd_i           (conv_bcd),
        .ready_o         (emit_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ascii_char    (m_ascii_char),
        .m_char_position (m_char_position),
        .m_is_last       (m_is_last)
    );

endmodule

// File: design/sidec_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
module sidec_dabble #(
    parameter int DATA_WIDTH = sidec_pkg::DATA_WIDTH_DEF,
    parameter int NUM_DIGITS = sidec_pkg::NUM_DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [DATA_WIDTH-1:0]                s_value,
    output sidec_pkg::conv_ctl_t                 ctl_o,
    output logic [NUM_DIGITS*sidec_pkg::DIGIT_W-1:0] bcd_o,
    input  logic                                 take_i
);
    import sidec_pkg::*;

    localparam int BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    conv_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic                  neg_reg, neg_next;
    logic [BCD_W-1:0]      bcd_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Sequencer: load magnitude, shift DATA_WIDTH bits, hold until taken
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    neg_next   = s_value[DATA_WIDTH-1];
                    mag_next   = s_value[DATA_WIDTH-1] ? (~s_value) + DATA_WIDTH'(1) : s_value;
                    bcd_next   = '0;
                    cnt_next   = CNT_W'(DATA_WIDTH - 1);
                    state_next = C_SHIFT;
                end
            end
            C_SHIFT: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[DATA_WIDTH-1]};
                mag_next = {mag_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                if (take_i) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign ctl_o.valid = (state_reg == C_DONE);
    assign ctl_o.neg   = neg_reg;
    assign bcd_o       = bcd_reg;

endmodule

// File: design/sidec_emit.sv
// Character emitter: strips leading zeros, then sends sign and digits one per cycle while m_ready allows.
module sidec_emit #(
    parameter int NUM_DIGITS = sidec_pkg::NUM_DIGITS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  sidec_pkg::conv_ctl_t                     ctl_i,
    input  logic [NUM_DIGITS*sidec_pkg::DIGIT_W-1:0] bcd_i,
    output logic                                     ready_o,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [sidec_pkg::CHAR_W-1:0]             m_ascii_char,
    output logic [sidec_pkg::POS_W-1:0]              m_char_position,
    output logic                                     m_is_last
);
    import sidec_pkg::*;

    localparam int BCD_W  = NUM_DIGITS * DIGIT_W;
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

    emit_state_t        state_reg, state_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  m_char_reg, m_char_next;
    logic [POS_W-1:0]   m_pos_reg;
    logic               m_last_reg, m_last_next;
    logic               out_load;
    logic               out_free;
    logic [DIGIT_W-1:0] top_digit;

    assign out_free  = !m_valid_reg || m_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // Sequencer and output register load
    always_comb begin
        state_next   = state_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        out_load     = 1'b0;
        ready_o      = 1'b0;
        unique case (state_reg)
            E_IDLE: begin
                ready_o = 1'b1;
                if (ctl_i.valid) begin
                    bcd_next   = bcd_i;
                    neg_next   = ctl_i.neg;
                    left_next  = LEFT_W'(NUM_DIGITS);
                    pos_next   = POS_W'(1);
                    state_next = E_STRIP;
                end
            end
            E_STRIP: begin
                // drop one leading zero per cycle, keep at least one digit
                if (top_digit == '0 && left_reg > LEFT_W'(1)) begin
                    bcd_next  = bcd_reg << DIGIT_W;
                    left_next = left_reg - LEFT_W'(1);
                end else begin
                    state_next = neg_reg ? E_SIGN : E_DIGITS;
                end
            end
            E_SIGN: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                    pos_next     = pos_reg + POS_W'(1);
                    state_next   = E_DIGITS;
                end
            end
            E_DIGITS: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                    m_last_next  = (left_reg == LEFT_W'(1));
                    bcd_next     = bcd_reg << DIGIT_W;
                    left_next    = left_reg - LEFT_W'(1);
                    pos_next     = pos_reg + POS_W'(1);
                    if (left_reg == LEFT_W'(1)) begin
                        state_next = E_IDLE;
                    end
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            m_valid_reg <= 1'b0;
            left_reg    <= '0;
            pos_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            left_reg    <= left_next;
            pos_reg     <= pos_next;
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        if (out_load) begin
            m_char_reg <= m_char_next;
            m_pos_reg  <= pos_reg;
            m_last_reg <= m_last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ascii_char    = m_char_reg;
    assign m_char_position = m_pos_reg;
    assign m_is_last       = m_last_reg;

`ifndef NO_ASSERTIONS
    // a minus sign is always followed by digits
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ascii_char == CHAR_MINUS |-> !m_is_last)
        else $error("minus sign flagged as last item");

    // a minus sign only opens a number
    a_minus_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ascii_char == CHAR_MINUS |-> m_char_position == POS_W'(1))
        else $error("minus sign not at first position");

    // every other character is a decimal digit
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ascii_char != CHAR_MINUS |->
            m_ascii_char >= CHAR_ZERO && m_ascii_char <= CHAR_ZERO + 8'd9)
        else $error("character is not a digit");

    // a new number is taken only with the digit counter spent
    a_take_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_i.valid && ready_o |-> left_reg == '0)
        else $error("new number taken mid-emission");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 100ps

module testbench;
    import sidec_pkg::*;

    localparam int DW        = DATA_WIDTH_DEF;
    localparam int DRAIN_CYC = 80;     // covers load, shift, strip and emit of one number
    localparam int HOLD_CYC  = 400;    // long result-side hold-off

    // One expected character of the decimal text
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic              last;
    } text_char_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [DW-1:0]        s_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CHAR_W-1:0]    m_ascii_char;
    logic [POS_W-1:0]     m_char_position;
    logic                 m_is_last;

    logic [DW-1:0]        pending_values[$];
    text_char_t           expected_text[$];
    int                   total_numbers = 0;
    int                   numbers_sent  = 0;
    int                   negatives     = 0;
    int                   chars_checked = 0;
    int                   errors        = 0;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   hold_left     = 0;
    bit                   hold_done     = 1'b0;

    signed_int_to_decimal_ascii_top #(.DATA_WIDTH(DW)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ascii_char    (m_ascii_char),
        .m_char_position (m_char_position),
        .m_is_last       (m_is_last)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Append the decimal text of one number to the expected characters
    function automatic void predict_decimal_text(input logic [DW-1:0] value);
        logic [DW-1:0] mag;
        logic [3:0]    digs[0:19];
        int            nd;
        int            total;
        int            k;
        int            i;
        bit            neg;
        text_char_t    c;
        neg = value[DW-1];
        // unsigned negate, so the most negative value keeps its full magnitude
        mag = neg ? (~value + 1'b1) : value;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        total = nd + (neg ? 1 : 0);
        k = 0;
        if (neg) begin
            c.ch   = CHAR_MINUS;
            c.pos  = POS_W'(1);
            c.last = (total == 1);
            expected_text.push_back(c);
            k = 1;
        end
        for (i = nd - 1; i >= 0; i--) begin
            c.ch   = CHAR_ZERO + CHAR_W'(digs[i]);
            c.pos  = POS_W'(k + 1);
            c.last = (k + 1 == total);
            expected_text.push_back(c);
            k++;
        end
    endfunction

    // Random number biased toward short texts, digit-count edges and extremes
    function automatic logic [DW-1:0] random_number();
        logic [DW-1:0] mag;
        logic [DW-1:0] p10;
        int            d;
        p10 = 1;
        case ($urandom_range(0, 4))
            0: return DW'($urandom);
            1: mag = DW'($urandom_range(0, 99));
            2: begin
                d = $urandom_range(0, 9);
                repeat (d) p10 = p10 * 10;
                mag = p10 + DW'($urandom_range(0, 2)) - 1'b1;
            end
            3: begin
                d = $urandom_range(1, 9);
                repeat (d) p10 = p10 * 10;
                mag = DW'($urandom_range(0, p10 - 1));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return {1'b0, {(DW-1){1'b1}}};
                    1: return {1'b1, {(DW-1){1'b0}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
        return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
    endfunction

    // Idle rates by run phase: sender light / receiver heavy, swapped, then none
    always_comb begin
        if (numbers_sent < total_numbers / 3) begin
            send_idle_pct  = 30;
            recv_stall_pct = 54;
        end else if (numbers_sent < 2 * total_numbers / 3) begin
            send_idle_pct  = 54;
            recv_stall_pct = 30;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    end

    // Long result-side hold-off once, in the no-idle phase, so the input backs up
    always @(posedge aclk) begin
        if (!hold_done && numbers_sent >= (5 * total_numbers) / 6 && total_numbers > 0) begin
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Driver: offers queued numbers, predicting text on each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_decimal_text(s_value);
                numbers_sent++;
                if (s_value[DW-1]) negatives++;
            end
            if (!s_valid || s_ready) begin
                if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_value <= pending_values.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready and result checking
    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected char 0x%02h pos %0d last %0d at %0t",
                                 m_ascii_char, m_char_position, m_is_last, $realtime);
                end else begin
                    want = expected_text.pop_front();
                    chars_checked++;
                    if (m_ascii_char !== want.ch || m_char_position !== want.pos ||
                        m_is_last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at %0t: expected %02h/%0d/%0d got %02h/%0d/%0d",
                                     $realtime, want.ch, want.pos, want.last,
                                     m_ascii_char, m_char_position, m_is_last);
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [DW-1:0] corner[$];
        corner = '{0, 1, '1, 9, 10, -10, 99, 100, -5, 7,
                   {1'b0, {(DW-1){1'b1}}}, {1'b1, {(DW-1){1'b0}}},
                   {1'b1, {(DW-2){1'b0}}, 1'b1}, 32'h7FFF_FFFE,
                   1000000000, -999999999, 1234567890, 999999999,
                   32'h5555_5555, 32'hAAAA_AAAA, -1000000000};
        foreach (corner[i]) pending_values.push_back(corner[i]);
        repeat (80) pending_values.push_back(random_number());
        total_numbers = pending_values.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (numbers_sent < total_numbers || expected_text.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);

        $display("Converted %0d numbers (%0d negative), %0d characters checked, %0d errors",
                 numbers_sent, negatives, chars_checked, errors);
        $display("Covered zero, both extremes, digit-count edges and a long output stall");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3ms;
        $display("Timeout: %0d of %0d numbers sent, %0d characters outstanding",
                 numbers_sent, total_numbers, expected_text.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
